// File: hw/rtl/altbl_pkg.sv
// shared constants, codes and types of the linked list table
package altbl_pkg;

	localparam int SLOTS   = 16;
	localparam int ID_BITS = 16;
	localparam int SLOT_W  = $clog2(SLOTS);
	localparam int IDX_W   = $clog2(SLOTS + 1);
	localparam int KEY_W   = 16;
	localparam int TAG_W   = 64;

	localparam logic [IDX_W-1:0]   NULL_IDX = IDX_W'(SLOTS);
	localparam logic [ID_BITS-1:0] ID_TOP   = {ID_BITS{1'b1}};

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_SEARCH = 2'd2,
		REQ_LIST   = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		STAT_OK       = 3'd0,
		STAT_FULL     = 3'd1,
		STAT_BADPRIO  = 3'd2,
		STAT_NOTFOUND = 3'd3,
		STAT_EMPTY    = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_FREE,
		S_INS_WALK,
		S_FIND,
		S_LIST_WALK,
		S_REM_LINK,
		S_REM_FREE
	} state_t;

	// write commands to the slot store
	typedef struct packed {
		logic               fill_en;
		logic [SLOT_W-1:0]  fill_idx;
		logic [ID_BITS-1:0] fill_id;
		logic [1:0]         fill_prio;
		logic [TAG_W-1:0]   fill_title;
		logic [TAG_W-1:0]   fill_detail;
		logic               link_en;
		logic [SLOT_W-1:0]  link_idx;
		logic [IDX_W-1:0]   link_val;
		logic               free_en;
		logic [SLOT_W-1:0]  free_idx;
	} store_wr_t;

	// contents of the slot at the read index
	typedef struct packed {
		logic [ID_BITS-1:0] id;
		logic [1:0]         prio;
		logic [TAG_W-1:0]   title;
		logic [TAG_W-1:0]   detail;
		logic [IDX_W-1:0]   next;
	} slot_rd_t;

	// one result item
	typedef struct packed {
		status_t          status;
		logic [15:0]      id;
		logic [1:0]       prio;
		logic [TAG_W-1:0] title;
		logic [TAG_W-1:0] detail;
		logic             last;
	} res_t;

endpackage

// File: hw/rtl/altbl_store.sv
// slot table: payload arrays, next links and used flags
module altbl_store (
	input  logic                                clk,
	input  logic                                arst_n,
	input  altbl_pkg::store_wr_t                wr,
	input  logic [altbl_pkg::SLOT_W-1:0]        rd_idx,
	output altbl_pkg::slot_rd_t                 rd,
	output logic [altbl_pkg::SLOTS-1:0]         used
);

	logic [altbl_pkg::ID_BITS-1:0] id_q     [altbl_pkg::SLOTS];
	logic [1:0]                    prio_q   [altbl_pkg::SLOTS];
	logic [altbl_pkg::TAG_W-1:0]   title_q  [altbl_pkg::SLOTS];
	logic [altbl_pkg::TAG_W-1:0]   detail_q [altbl_pkg::SLOTS];
	logic [altbl_pkg::IDX_W-1:0]   next_q   [altbl_pkg::SLOTS];
	logic [altbl_pkg::SLOTS-1:0]   used_q;
	logic [altbl_pkg::IDX_W-1:0]   next_raw;

	// payload written on fill, no reset
	always_ff @(posedge clk) begin
		if (wr.fill_en) begin
			id_q[wr.fill_idx]     <= wr.fill_id;
			prio_q[wr.fill_idx]   <= wr.fill_prio;
			title_q[wr.fill_idx]  <= wr.fill_title;
			detail_q[wr.fill_idx] <= wr.fill_detail;
		end
	end

	// links and used flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			for (int i = 0; i < altbl_pkg::SLOTS; i++) begin
				next_q[i] <= altbl_pkg::NULL_IDX;
			end
		end else begin
			if (wr.fill_en) begin
				used_q[wr.fill_idx] <= 1'b1;
				next_q[wr.fill_idx] <= altbl_pkg::NULL_IDX;
			end
			if (wr.link_en) begin
				next_q[wr.link_idx] <= wr.link_val;
			end
			if (wr.free_en) begin
				used_q[wr.free_idx] <= 1'b0;
				next_q[wr.free_idx] <= altbl_pkg::NULL_IDX;
			end
		end
	end

	// single read port, out-of-range links read as null
	assign next_raw  = next_q[rd_idx];
	assign rd.id     = id_q[rd_idx];
	assign rd.prio   = prio_q[rd_idx];
	assign rd.title  = title_q[rd_idx];
	assign rd.detail = detail_q[rd_idx];
	assign rd.next   = (next_raw >= altbl_pkg::NULL_IDX) ? altbl_pkg::NULL_IDX : next_raw;
	assign used      = used_q;

endmodule

// File: hw/rtl/array_linked_list_table.sv
// top level of the linked list table: request sequencer and result register
//
//  channel | signals                                        | handshake
//  --------+------------------------------------------------+---------------------
//  in      | req_type prio_code title_tag detail_tag key_id | in_valid / in_ready
//  out     | status entry_id entry_prio entry_title         | out_valid / out_ready
//          | entry_detail last                              |
//
// one request at a time; a single slot read port follows one link per cycle.
// insert: takes the lowest free slot, links it at the tail (head if list empty).
// remove/search: walk from the head to the key; remove then unlinks and frees it.
// list: one item per entry emitted; empty list gives one status item.
// a pending result holds the sequencer where it emits an item and where an insert
// takes its slot.
// reset clears used flags, links, head and sets the id counter to one.
module array_linked_list_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [2:0]  prio_code,
	input  logic [63:0] title_tag,
	input  logic [63:0] detail_tag,
	input  logic [15:0] key_id,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [15:0] entry_id,
	output logic [1:0]  entry_prio,
	output logic [63:0] entry_title,
	output logic [63:0] entry_detail,
	output logic        last
);

	localparam int SLOTS   = altbl_pkg::SLOTS;
	localparam int SLOT_W  = altbl_pkg::SLOT_W;
	localparam int IDX_W   = altbl_pkg::IDX_W;
	localparam int ID_BITS = altbl_pkg::ID_BITS;

	altbl_pkg::state_t state_q, state_d;

	// latched request
	altbl_pkg::req_t           req_q;
	logic [2:0]                prio_q;
	logic [63:0]               title_q;
	logic [63:0]               detail_q;
	logic [15:0]               key_q;

	// walk registers
	logic [IDX_W-1:0]   cur_q, cur_d;
	logic [IDX_W-1:0]   prev_q, prev_d;
	logic [IDX_W-1:0]   steps_q, steps_d;
	logic [IDX_W-1:0]   nxt_q, nxt_d;
	logic [SLOT_W-1:0]  slot_q, slot_d;
	logic [ID_BITS-1:0] newid_q, newid_d;
	logic [IDX_W-1:0]   head_q, head_d;
	logic [ID_BITS-1:0] serial_q, serial_d;

	// result register
	logic                out_valid_q;
	altbl_pkg::res_t     out_q;
	altbl_pkg::res_t     res;
	logic                emit;
	logic                out_free;

	altbl_pkg::store_wr_t wr;
	altbl_pkg::slot_rd_t  rd;
	logic [SLOTS-1:0]     used;

	logic               free_found;
	logic [SLOT_W-1:0]  free_idx;
	logic               prio_ok;
	logic               cur_null;
	logic               accept;

	altbl_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.rd_idx (cur_q[SLOT_W-1:0]),
		.rd     (rd),
		.used   (used)
	);

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!used[i]) begin
				free_found = 1'b1;
				free_idx   = SLOT_W'(i);
			end
		end
	end

	assign prio_ok  = prio_q inside {[3'd1:3'd3]};
	assign cur_null = (cur_q >= altbl_pkg::NULL_IDX);
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == altbl_pkg::S_IDLE);
	assign accept   = in_valid && in_ready;

	// sequencer next state and outputs
	always_comb begin
		state_d  = state_q;
		cur_d    = cur_q;
		prev_d   = prev_q;
		steps_d  = steps_q;
		nxt_d    = nxt_q;
		slot_d   = slot_q;
		newid_d  = newid_q;
		head_d   = head_q;
		serial_d = serial_q;
		emit     = 1'b0;
		res      = '{status: altbl_pkg::STAT_OK, id: '0, prio: '0,
			title: '0, detail: '0, last: 1'b1};
		wr       = '0;

		case (state_q)
			altbl_pkg::S_IDLE: begin
				if (accept) begin
					cur_d   = (head_q >= altbl_pkg::NULL_IDX) ? altbl_pkg::NULL_IDX : head_q;
					prev_d  = altbl_pkg::NULL_IDX;
					steps_d = '0;
					case (altbl_pkg::req_t'(req_type))
						altbl_pkg::REQ_INSERT: state_d = altbl_pkg::S_INS_FREE;
						altbl_pkg::REQ_LIST:   state_d = altbl_pkg::S_LIST_WALK;
						default:               state_d = altbl_pkg::S_FIND;
					endcase
				end
			end

			altbl_pkg::S_INS_FREE: begin
				if (out_free) begin
					if (!free_found) begin
						emit       = 1'b1;
						res.status = altbl_pkg::STAT_FULL;
						state_d    = altbl_pkg::S_IDLE;
					end else begin
						newid_d = serial_q;
						if (serial_q != altbl_pkg::ID_TOP) begin
							serial_d = serial_q + ID_BITS'(1);
						end
						if (!prio_ok) begin
							emit       = 1'b1;
							res.status = altbl_pkg::STAT_BADPRIO;
							res.id     = 16'(serial_q);
							state_d    = altbl_pkg::S_IDLE;
						end else begin
							wr.fill_en     = 1'b1;
							wr.fill_idx    = free_idx;
							wr.fill_id     = serial_q;
							wr.fill_prio   = prio_q[1:0];
							wr.fill_title  = title_q;
							wr.fill_detail = detail_q;
							slot_d         = free_idx;
							if (cur_null) begin
								head_d     = IDX_W'(free_idx);
								emit       = 1'b1;
								res.id     = 16'(serial_q);
								res.prio   = prio_q[1:0];
								res.title  = title_q;
								res.detail = detail_q;
								state_d    = altbl_pkg::S_IDLE;
							end else begin
								state_d = altbl_pkg::S_INS_WALK;
							end
						end
					end
				end
			end

			altbl_pkg::S_INS_WALK: begin
				if (steps_q < IDX_W'(SLOTS) && rd.next != altbl_pkg::NULL_IDX) begin
					cur_d   = rd.next;
					steps_d = steps_q + IDX_W'(1);
				end else if (out_free) begin
					// hook new slot onto the tail
					wr.link_en  = 1'b1;
					wr.link_idx = cur_q[SLOT_W-1:0];
					wr.link_val = IDX_W'(slot_q);
					emit        = 1'b1;
					res.id      = 16'(newid_q);
					res.prio    = prio_q[1:0];
					res.title   = title_q;
					res.detail  = detail_q;
					state_d     = altbl_pkg::S_IDLE;
				end
			end

			altbl_pkg::S_FIND: begin
				if (cur_null || steps_q >= IDX_W'(SLOTS)) begin
					if (out_free) begin
						emit       = 1'b1;
						res.status = altbl_pkg::STAT_NOTFOUND;
						state_d    = altbl_pkg::S_IDLE;
					end
				end else if (rd.id == ID_BITS'(key_q)) begin
					if (out_free) begin
						emit       = 1'b1;
						res.id     = 16'(rd.id);
						res.prio   = rd.prio;
						res.title  = rd.title;
						res.detail = rd.detail;
						nxt_d      = rd.next;
						state_d    = (req_q == altbl_pkg::REQ_REMOVE) ?
							altbl_pkg::S_REM_LINK : altbl_pkg::S_IDLE;
					end
				end else begin
					prev_d  = cur_q;
					cur_d   = rd.next;
					steps_d = steps_q + IDX_W'(1);
				end
			end

			altbl_pkg::S_REM_LINK: begin
				// bypass the removed entry
				if (prev_q >= altbl_pkg::NULL_IDX) begin
					head_d = nxt_q;
				end else begin
					wr.link_en  = 1'b1;
					wr.link_idx = prev_q[SLOT_W-1:0];
					wr.link_val = nxt_q;
				end
				state_d = altbl_pkg::S_REM_FREE;
			end

			altbl_pkg::S_REM_FREE: begin
				wr.free_en  = 1'b1;
				wr.free_idx = cur_q[SLOT_W-1:0];
				state_d     = altbl_pkg::S_IDLE;
			end

			altbl_pkg::S_LIST_WALK: begin
				if (out_free) begin
					emit = 1'b1;
					if (cur_null) begin
						res.status = altbl_pkg::STAT_EMPTY;
						state_d    = altbl_pkg::S_IDLE;
					end else begin
						res.id     = 16'(rd.id);
						res.prio   = rd.prio;
						res.title  = rd.title;
						res.detail = rd.detail;
						res.last   = (rd.next == altbl_pkg::NULL_IDX) ||
							(steps_q == IDX_W'(SLOTS - 1));
						cur_d      = rd.next;
						steps_d    = steps_q + IDX_W'(1);
						if (res.last) begin
							state_d = altbl_pkg::S_IDLE;
						end
					end
				end
			end

			default: begin
				state_d = altbl_pkg::S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= altbl_pkg::S_IDLE;
			head_q      <= altbl_pkg::NULL_IDX;
			serial_q    <= ID_BITS'(1);
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			head_q   <= head_d;
			serial_q <= serial_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request, walk and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q    <= altbl_pkg::req_t'(req_type);
			prio_q   <= prio_code;
			title_q  <= title_tag;
			detail_q <= detail_tag;
			key_q    <= key_id;
		end
		cur_q   <= cur_d;
		prev_q  <= prev_d;
		steps_q <= steps_d;
		nxt_q   <= nxt_d;
		slot_q  <= slot_d;
		newid_q <= newid_d;
		if (emit) begin
			out_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_q.status;
	assign entry_id     = out_q.id;
	assign entry_prio   = out_q.prio;
	assign entry_title  = out_q.title;
	assign entry_detail = out_q.detail;
	assign last         = out_q.last;

endmodule

// File: dv/testbench.sv
// self-checking testbench for the array linked list table
`timescale 1ns / 1ps

module testbench;

	localparam int STALL_LIMIT = 4000;
	localparam int IDLE_PCT    = 15;

	// mirror of the slot table: predicts every result item of each request
	class table_mirror;
		logic                         used    [altbl_pkg::SLOTS];
		logic [altbl_pkg::IDX_W-1:0]   link    [altbl_pkg::SLOTS];
		logic [altbl_pkg::ID_BITS-1:0] ids     [altbl_pkg::SLOTS];
		logic [1:0]                   prios   [altbl_pkg::SLOTS];
		logic [altbl_pkg::TAG_W-1:0]   titles  [altbl_pkg::SLOTS];
		logic [altbl_pkg::TAG_W-1:0]   details [altbl_pkg::SLOTS];
		logic [altbl_pkg::IDX_W-1:0]   head;
		logic [altbl_pkg::ID_BITS-1:0] serial;
		altbl_pkg::res_t              due_replies[$];
		int                           errors;
		int                           requests;
		int                           replies;
		int                           seen_status[5];

		function new();
			foreach (used[i]) begin
				used[i] = 1'b0;
				link[i] = altbl_pkg::NULL_IDX;
			end
			head = altbl_pkg::NULL_IDX;
			serial = 1;
			errors = 0;
			requests = 0;
			replies = 0;
			foreach (seen_status[i]) seen_status[i] = 0;
		endfunction

		function altbl_pkg::res_t reply(altbl_pkg::status_t st, logic [15:0] id,
				logic [1:0] pr, logic [altbl_pkg::TAG_W-1:0] ti,
				logic [altbl_pkg::TAG_W-1:0] de, logic lst);
			altbl_pkg::res_t r;
			r.status = st;
			r.id = id;
			r.prio = pr;
			r.title = ti;
			r.detail = de;
			r.last = lst;
			return r;
		endfunction

		function altbl_pkg::res_t slot_reply(int s, logic lst);
			return reply(altbl_pkg::STAT_OK, ids[s][15:0], prios[s], titles[s], details[s],
				lst);
		endfunction

		// lowest free slot, or SLOTS when the table is full
		function int free_slot();
			for (int i = 0; i < altbl_pkg::SLOTS; i++)
				if (!used[i]) return i;
			return altbl_pkg::SLOTS;
		endfunction

		// id of a random live entry, or any id when the table is empty
		function logic [15:0] live_id();
			int live[$];
			for (int i = 0; i < altbl_pkg::SLOTS; i++)
				if (used[i]) live.push_back(i);
			if (live.size() == 0) return 16'($urandom);
			return ids[live[$urandom_range(live.size() - 1)]][15:0];
		endfunction

		function int due_count();
			return due_replies.size();
		endfunction

		// apply one accepted request and queue the results it causes
		function void take_request(altbl_pkg::req_t rq, logic [2:0] pr,
				logic [altbl_pkg::TAG_W-1:0] ti, logic [altbl_pkg::TAG_W-1:0] de,
				logic [15:0] key);
			int s;
			logic [altbl_pkg::IDX_W-1:0] cur;
			logic [altbl_pkg::IDX_W-1:0] prv;
			logic [altbl_pkg::ID_BITS-1:0] nid;
			requests++;
			case (rq)
				altbl_pkg::REQ_INSERT: begin
					s = free_slot();
					if (s == altbl_pkg::SLOTS) begin
						due_replies.push_back(reply(altbl_pkg::STAT_FULL, '0, '0, '0, '0, 1'b1));
					end else begin
						nid = serial;
						if (serial != altbl_pkg::ID_TOP) serial++;
						if (pr < 3'd1 || pr > 3'd3) begin
							due_replies.push_back(reply(altbl_pkg::STAT_BADPRIO, nid[15:0],
								'0, '0, '0, 1'b1));
						end else begin
							used[s] = 1'b1;
							ids[s] = nid;
							prios[s] = pr[1:0];
							titles[s] = ti;
							details[s] = de;
							link[s] = altbl_pkg::NULL_IDX;
							// append at the tail
							if (head == altbl_pkg::NULL_IDX) begin
								head = altbl_pkg::IDX_W'(s);
							end else begin
								cur = head;
								while (link[cur] != altbl_pkg::NULL_IDX) cur = link[cur];
								link[cur] = altbl_pkg::IDX_W'(s);
							end
							due_replies.push_back(slot_reply(s, 1'b1));
						end
					end
				end
				altbl_pkg::REQ_LIST: begin
					if (head == altbl_pkg::NULL_IDX) begin
						due_replies.push_back(reply(altbl_pkg::STAT_EMPTY, '0, '0, '0, '0, 1'b1));
					end else begin
						cur = head;
						while (cur != altbl_pkg::NULL_IDX) begin
							due_replies.push_back(slot_reply(cur,
								link[cur] == altbl_pkg::NULL_IDX));
							cur = link[cur];
						end
					end
				end
				default: begin
					// remove or search acts on the first entry with the key
					cur = head;
					prv = altbl_pkg::NULL_IDX;
					while (cur != altbl_pkg::NULL_IDX && ids[cur] != key) begin
						prv = cur;
						cur = link[cur];
					end
					if (cur == altbl_pkg::NULL_IDX) begin
						due_replies.push_back(reply(altbl_pkg::STAT_NOTFOUND, '0, '0, '0, '0,
							1'b1));
					end else begin
						due_replies.push_back(slot_reply(cur, 1'b1));
						if (rq == altbl_pkg::REQ_REMOVE) begin
							if (prv == altbl_pkg::NULL_IDX) head = link[cur];
							else link[prv] = link[cur];
							used[cur] = 1'b0;
							link[cur] = altbl_pkg::NULL_IDX;
						end
					end
				end
			endcase
		endfunction

		function void flag(string what, logic [63:0] want, logic [63:0] got);
			errors++;
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
		endfunction

		// compare one accepted result item with the oldest prediction
		function void check_reply(logic [2:0] st, logic [15:0] id, logic [1:0] pr,
				logic [altbl_pkg::TAG_W-1:0] ti, logic [altbl_pkg::TAG_W-1:0] de, logic lst);
			altbl_pkg::res_t want;
			replies++;
			if (due_replies.size() == 0) begin
				errors++;
				$display("%0t: unexpected result item: expected none, actual status %0h id %0h",
					$time, st, id);
				return;
			end
			want = due_replies.pop_front();
			seen_status[want.status]++;
			if (want.status !== st) flag("status", 64'(want.status), 64'(st));
			if (want.id !== id) flag("entry_id", 64'(want.id), 64'(id));
			if (want.prio !== pr) flag("entry_prio", 64'(want.prio), 64'(pr));
			if (want.title !== ti) flag("entry_title", want.title, ti);
			if (want.detail !== de) flag("entry_detail", want.detail, de);
			if (want.last !== lst) flag("last", 64'(want.last), 64'(lst));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  req_type = '0;
	logic [2:0]  prio_code = '0;
	logic [63:0] title_tag = '0;
	logic [63:0] detail_tag = '0;
	logic [15:0] key_id = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  status;
	logic [15:0] entry_id;
	logic [1:0]  entry_prio;
	logic [63:0] entry_title;
	logic [63:0] entry_detail;
	logic        last;

	bit          calm = 1'b0;
	int          quiet_cycles = 0;
	table_mirror mirror = new();

	array_linked_list_table DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.prio_code(prio_code),
		.title_tag(title_tag),
		.detail_tag(detail_tag),
		.key_id(key_id),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.entry_id(entry_id),
		.entry_prio(entry_prio),
		.entry_title(entry_title),
		.entry_detail(entry_detail),
		.last(last)
	);

	always #5 clk = ~clk;

	// result side: check accepted items, then pick the next ready
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			mirror.check_reply(status, entry_id, entry_prio, entry_title, entry_detail, last);
		out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
	end

	// watchdog on cycles without any accepted item
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no item accepted for %0d cycles", $time, STALL_LIMIT);
			$display("simulation failed");
			$finish;
		end
	end

	// offer one request item and hold it until accepted
	task automatic send_request(altbl_pkg::req_t rq, logic [2:0] pr, logic [63:0] ti,
			logic [63:0] de, logic [15:0] key);
		req_type <= rq;
		prio_code <= pr;
		title_tag <= ti;
		detail_tag <= de;
		key_id <= key;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_ready !== 1'b1);
		mirror.take_request(rq, pr, ti, de, key);
		if (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 40);
		end
	endtask

	function automatic logic [63:0] any_tag();
		return {$urandom, $urandom};
	endfunction

	// insert with a valid priority most of the time
	function automatic logic [2:0] any_prio();
		if ($urandom_range(9) == 0) return 3'($urandom);
		return 3'($urandom_range(3, 1));
	endfunction

	// one random request; keys mostly hit live entries
	task automatic random_request(int ins_pct, int rem_pct, int srch_pct);
		int r;
		logic [15:0] key;
		r = $urandom_range(99);
		key = ($urandom_range(3) == 0) ? 16'($urandom) : mirror.live_id();
		if (r < ins_pct)
			send_request(altbl_pkg::REQ_INSERT, any_prio(), any_tag(), any_tag(),
				16'($urandom));
		else if (r < ins_pct + rem_pct)
			send_request(altbl_pkg::REQ_REMOVE, 3'($urandom), any_tag(), any_tag(), key);
		else if (r < ins_pct + rem_pct + srch_pct)
			send_request(altbl_pkg::REQ_SEARCH, 3'($urandom), any_tag(), any_tag(), key);
		else
			send_request(altbl_pkg::REQ_LIST, 3'($urandom), any_tag(), any_tag(), key);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// empty table, rejected priorities, extreme tags, unlink at each position
		send_request(altbl_pkg::REQ_LIST, '0, '0, '0, '0);
		send_request(altbl_pkg::REQ_SEARCH, '0, '0, '0, 16'h0000);
		send_request(altbl_pkg::REQ_REMOVE, '0, '0, '0, 16'hFFFF);
		send_request(altbl_pkg::REQ_INSERT, 3'd0, any_tag(), any_tag(), '0);
		send_request(altbl_pkg::REQ_INSERT, 3'd7, any_tag(), any_tag(), '1);
		send_request(altbl_pkg::REQ_INSERT, 3'd4, any_tag(), any_tag(), '0);
		send_request(altbl_pkg::REQ_INSERT, 3'd1, '1, '0, '0);
		send_request(altbl_pkg::REQ_INSERT, 3'd2, '0, '1, '1);
		send_request(altbl_pkg::REQ_INSERT, 3'd3, any_tag(), any_tag(), '0);
		send_request(altbl_pkg::REQ_SEARCH, '0, '0, '0, 16'd5);
		send_request(altbl_pkg::REQ_SEARCH, '1, '1, '1, 16'd1);
		send_request(altbl_pkg::REQ_REMOVE, '0, '0, '0, 16'd5);
		send_request(altbl_pkg::REQ_LIST, '0, '0, '0, '0);
		send_request(altbl_pkg::REQ_INSERT, 3'd1, any_tag(), any_tag(), '0);
		send_request(altbl_pkg::REQ_REMOVE, '0, '0, '0, 16'd4);
		send_request(altbl_pkg::REQ_LIST, '0, '0, '0, '0);
		send_request(altbl_pkg::REQ_REMOVE, '0, '0, '0, 16'd7);
		send_request(altbl_pkg::REQ_SEARCH, '0, '0, '0, 16'd7);
		send_request(altbl_pkg::REQ_REMOVE, '0, '0, '0, 16'd6);
		send_request(altbl_pkg::REQ_LIST, '0, '0, '0, '0);

		// fill the table, overflow it, then list all sixteen entries
		while (mirror.free_slot() != altbl_pkg::SLOTS)
			send_request(altbl_pkg::REQ_INSERT, 3'($urandom_range(3, 1)), any_tag(),
				any_tag(), '0);
		send_request(altbl_pkg::REQ_INSERT, 3'd2, any_tag(), any_tag(), '0);
		send_request(altbl_pkg::REQ_INSERT, 3'd5, any_tag(), any_tag(), '0);
		send_request(altbl_pkg::REQ_LIST, '0, '0, '0, '0);

		// random phases that swing between filling and draining
		for (int phase = 0; phase < 10; phase++) begin
			calm = (phase == 4);
			for (int n = 0; n < 40; n++) begin
				case (phase % 3)
					0: random_request(55, 15, 15);
					1: random_request(20, 45, 20);
					default: random_request(35, 25, 25);
				endcase
			end
		end
		calm = 1'b0;

		// closing probes of the top id and a final listing
		send_request(altbl_pkg::REQ_SEARCH, '0, '0, '0, 16'hFFFF);
		send_request(altbl_pkg::REQ_REMOVE, '0, '0, '0, 16'hFFFF);
		send_request(altbl_pkg::REQ_LIST, '0, '0, '0, '0);
		in_valid <= 1'b0;

		// drain the remaining results, then watch for stray items
		while (mirror.due_count() != 0) @(posedge clk);
		repeat (4 * altbl_pkg::SLOTS) @(posedge clk);

		$display("covered %0d requests and %0d result items, id counter ended at %0h",
			mirror.requests, mirror.replies, mirror.serial);
		$display("status counts: ok %0d, full %0d, bad priority %0d, not found %0d, empty %0d",
			mirror.seen_status[altbl_pkg::STAT_OK], mirror.seen_status[altbl_pkg::STAT_FULL],
			mirror.seen_status[altbl_pkg::STAT_BADPRIO],
			mirror.seen_status[altbl_pkg::STAT_NOTFOUND],
			mirror.seen_status[altbl_pkg::STAT_EMPTY]);
		if (mirror.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// File: array_linked_list_table.f
hw/rtl/altbl_pkg.sv
hw/rtl/altbl_store.sv
hw/rtl/array_linked_list_table.sv
dv/testbench.sv
